@@ rtl/apr_pkg.sv @@
// Shared types, constants and helpers for the axis point rotation block.
// Used by the top level, the trig unit and the port checker.
package apr_pkg;

    // Coordinate width is fixed by the Q16.16 payload fields
    localparam int COORD_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int ANGLE_WIDTH     = 18;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_SELECT    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROTATION_ANGLE = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_X        = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Y        = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Z        = 3'd4;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Angle units: 1/256 degree
    localparam int HALF_TURN       = 180;
    localparam int STEPS_PER_DEG   = 256;
    localparam int FULL_TURN_STEPS = 2 * HALF_TURN * STEPS_PER_DEG;
    localparam int HALF_TURN_STEPS = HALF_TURN * STEPS_PER_DEG;
    localparam int QUARTER_STEPS   = HALF_TURN_STEPS / 2;

    // CORDIC: angles in 2^-16 degree, x/y in Q2.30
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_WIDTH = 32;
    localparam int CORDIC_ZW    = 25;
    localparam int STEP_WIDTH   = $clog2(CORDIC_STEPS);
    localparam int Z_SHIFT      = $clog2(65536 / STEPS_PER_DEG);
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

    typedef enum logic [1:0] {
        TRIG_IDLE,
        TRIG_ITER,
        TRIG_ROUND
    } trig_state_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          last_in;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic signed [COORD_WIDTH-1:0] rotated_z;
        logic                          last_out;
        logic                          overflow;
    } point_out_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [CORDIC_ZW-1:0] atan_step(input logic [STEP_WIDTH-1:0] i);
        logic signed [CORDIC_ZW-1:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/apr_trig.sv @@
// Cosine/sine unit: reduces the angle and runs an iterative CORDIC,
// one rotation step per cycle. Depends on apr_pkg.
module apr_trig import apr_pkg::*; #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ANGLE_WIDTH-1:0]       angle,
    output logic                                busy,
    output logic signed [TRIG_FRAC_BITS+1:0]    cosine,
    output logic signed [TRIG_FRAC_BITS+1:0]    sine
);

    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int RED_W = ANGLE_WIDTH + 2;
    localparam int XW    = CORDIC_WIDTH + 1;
    localparam int SH    = CORDIC_FRAC - TRIG_FRAC_BITS;

    localparam logic signed [RED_W-1:0] FULL_C    = RED_W'(FULL_TURN_STEPS);
    localparam logic signed [RED_W-1:0] HALF_C    = RED_W'(HALF_TURN_STEPS);
    localparam logic signed [RED_W-1:0] QUARTER_C = RED_W'(QUARTER_STEPS);
    localparam logic signed [TW-1:0]    ONE_T     = TW'(1) <<< TRIG_FRAC_BITS;
    localparam logic signed [XW-1:0]    ONE_X     = XW'(1) <<< TRIG_FRAC_BITS;
    localparam logic signed [XW-1:0]    RND_X     = XW'(1) <<< (SH - 1);
    localparam logic [STEP_WIDTH-1:0]   LAST_STEP = STEP_WIDTH'(CORDIC_STEPS - 1);

    trig_state_t                     state_reg, state_next;
    logic signed [CORDIC_WIDTH-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [CORDIC_ZW-1:0]     z_reg, z_next;
    logic [STEP_WIDTH-1:0]           step_reg, step_next;
    logic                            neg_reg, neg_next;
    logic signed [TW-1:0]            cos_reg, cos_next, sin_reg, sin_next;

    logic signed [RED_W-1:0]         ang_in, ang_a, ang_b, ang_c, red;
    logic                            red_neg;
    logic signed [CORDIC_WIDTH-1:0]  x_shift, y_shift;
    logic signed [CORDIC_ZW-1:0]     atan_val;
    logic signed [XW-1:0]            x_rnd, y_rnd;

    function automatic logic signed [XW-1:0] clamp_one(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = v;
        if (v > ONE_X)
        begin
            r = ONE_X;
        end
        else if (v < -ONE_X)
        begin
            r = -ONE_X;
        end
        return r;
    endfunction

    // Wrap to one turn, then fold into [-90, +90] degrees
    assign ang_in  = RED_W'(angle);
    assign ang_a   = (ang_in >= FULL_C)  ? ang_in - FULL_C :
                     (ang_in <= -FULL_C) ? ang_in + FULL_C : ang_in;
    assign ang_b   = (ang_a < 0) ? ang_a + FULL_C : ang_a;
    assign ang_c   = (ang_b > HALF_C) ? ang_b - FULL_C : ang_b;
    assign red_neg = (ang_c > QUARTER_C) || (ang_c < -QUARTER_C);
    assign red     = (ang_c > QUARTER_C)  ? ang_c - HALF_C :
                     (ang_c < -QUARTER_C) ? ang_c + HALF_C : ang_c;

    assign x_shift  = x_reg >>> step_reg;
    assign y_shift  = y_reg >>> step_reg;
    assign atan_val = atan_step(step_reg);

    assign x_rnd = clamp_one((XW'(x_reg) + RND_X) >>> SH);
    assign y_rnd = clamp_one((XW'(y_reg) + RND_X) >>> SH);

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        case (state_reg)
            TRIG_IDLE:
            begin
                state_next = TRIG_IDLE;
            end
            TRIG_ITER:
            begin
                if (!z_reg[CORDIC_ZW-1])
                begin
                    x_next = x_reg - y_shift;
                    y_next = y_reg + x_shift;
                    z_next = z_reg - atan_val;
                end
                else
                begin
                    x_next = x_reg + y_shift;
                    y_next = y_reg - x_shift;
                    z_next = z_reg + atan_val;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = TRIG_ROUND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            TRIG_ROUND:
            begin
                cos_next   = neg_reg ? TW'(-x_rnd) : TW'(x_rnd);
                sin_next   = neg_reg ? TW'(-y_rnd) : TW'(y_rnd);
                state_next = TRIG_IDLE;
            end
            default:
            begin
                state_next = TRIG_IDLE;
            end
        endcase

        // A new angle restarts the unit; exact quarter turns skip the iterations
        if (start)
        begin
            neg_next = red_neg;
            if (red == 0)
            begin
                cos_next   = red_neg ? -ONE_T : ONE_T;
                sin_next   = '0;
                state_next = TRIG_IDLE;
            end
            else if (red == QUARTER_C)
            begin
                cos_next   = '0;
                sin_next   = red_neg ? -ONE_T : ONE_T;
                state_next = TRIG_IDLE;
            end
            else if (red == -QUARTER_C)
            begin
                cos_next   = '0;
                sin_next   = red_neg ? ONE_T : -ONE_T;
                state_next = TRIG_IDLE;
            end
            else
            begin
                x_next     = CORDIC_GAIN;
                y_next     = '0;
                z_next     = CORDIC_ZW'(red) <<< Z_SHIFT;
                step_next  = '0;
                state_next = TRIG_ITER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TRIG_IDLE;
            step_reg  <= '0;
            cos_reg   <= ONE_T;
            sin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign busy   = (state_reg != TRIG_IDLE);
    assign cosine = cos_reg;
    assign sine   = sin_reg;

endmodule

@@ rtl/axis_point_rotation.sv @@
// Top level of the axis point rotation block: config registers, the
// four-stage point pipeline and the trig unit. Depends on apr_pkg, apr_trig.
//
// Usage:
//   Points enter on point/point_valid/point_stall and leave on
//   result/result_valid/result_stall; a transaction completes at a rising
//   edge with valid high and stall low. Each point is moved to the pivot,
//   rotated about the selected axis and moved back, with rounding and
//   saturation to Q16.16; overflow flags any clamped coordinate.
//   An accepted point passes the pipeline registers (input, pivot difference,
//   products, result) in order to result_valid. Throughput: one point per cycle
//   when not stalled by result_stall or the trig unit; every stage has its
//   own valid and fills bubbles, so new points are taken while a result waits.
//   Configuration: write enable, index and data, one register per edge.
//   A rotation_angle write starts the CORDIC unit: 20 iterations, then a
//   rounding step, with point_stall held high throughout.
//   Multiples of 90 degrees load exact values at the write edge.
//   Reset: pipeline empties, axis X, pivot zero, angle zero (cos 1, sin 0).
//   When the receiver stalls, the result holds and stages behind it fill
//   up; this reaches point_stall only once all four stages hold points.
module axis_point_rotation import apr_pkg::*; #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        point_valid,
    output logic                        point_stall,
    input  point_in_t                   point,
    output logic                        result_valid,
    input  logic                        result_stall,
    output point_out_t                  result,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int TW = TRIG_FRAC_BITS + 2;   // trig values, up to +-1.0
    localparam int DW = COORD_WIDTH + 1;      // point minus pivot
    localparam int PW = TW + DW;              // one product
    localparam int RW = COORD_WIDTH + 4;      // rotated value plus pivot

    localparam logic signed [PW:0]   RND_HALF = (PW + 1)'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_MAX  = RW'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [RW-1:0] SAT_MIN  = -SAT_MAX - 1;

    // Configuration registers
    logic [1:0]                    axis_reg;
    logic signed [COORD_WIDTH-1:0] pivot_x_reg, pivot_y_reg, pivot_z_reg;
    logic                          trig_start;
    logic                          trig_busy;
    logic signed [TW-1:0]          cos_value, sin_value;

    // Pipeline control
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, result_valid_reg;
    logic s0_ready, s1_ready, s2_ready, s3_ready;
    logic point_accept;

    // Stage 0: captured point
    point_in_t                     s0_point_reg;
    // Stage 1: differences and the pair across the axis
    logic signed [DW-1:0]          s1_dx_reg, s1_dy_reg, s1_dz_reg, s1_u_reg, s1_v_reg;
    logic signed [DW-1:0]          d_x, d_y, d_z, d_u, d_v;
    logic                          s1_last_reg;
    // Stage 2: products
    logic signed [PW-1:0]          s2_cu_reg, s2_sv_reg, s2_cv_reg, s2_su_reg;
    logic signed [PW-1:0]          prod_cu, prod_sv, prod_cv, prod_su;
    logic signed [DW-1:0]          s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic                          s2_last_reg;
    // Stage 3: result
    logic signed [PW:0]            acc_u, acc_v;
    logic signed [RW-1:0]          rot_u, rot_v, sel_x, sel_y, sel_z;
    logic [COORD_WIDTH:0]          sat_x, sat_y, sat_z;
    point_out_t                    result_reg, result_next;

    // Return {clamped flag, clamped value}
    function automatic logic [COORD_WIDTH:0] saturate(input logic signed [RW-1:0] v);
        logic [COORD_WIDTH:0] r;
        r = {1'b0, v[COORD_WIDTH-1:0]};
        if (v > SAT_MAX)
        begin
            r = {1'b1, SAT_MAX[COORD_WIDTH-1:0]};
        end
        else if (v < SAT_MIN)
        begin
            r = {1'b1, SAT_MIN[COORD_WIDTH-1:0]};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg    <= AXIS_X;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            pivot_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AXIS_SELECT:    axis_reg    <= cfg_data[1:0];
                REG_PIVOT_X:        pivot_x_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_PIVOT_Y:        pivot_y_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_PIVOT_Z:        pivot_z_reg <= cfg_data[COORD_WIDTH-1:0];
                default:            axis_reg    <= axis_reg;
            endcase
        end
    end

    assign trig_start = cfg_write && (cfg_index == REG_ROTATION_ANGLE);

    apr_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (trig_start),
        .angle  (cfg_data[ANGLE_WIDTH-1:0]),
        .busy   (trig_busy),
        .cosine (cos_value),
        .sine   (sin_value)
    );

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    assign s3_ready     = !result_valid_reg || !result_stall;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign s0_ready     = !s0_valid_reg || s1_ready;
    // Hold off points while cosine and sine are being refreshed
    assign point_stall  = !s0_ready || trig_busy;
    assign point_accept = point_valid && !point_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= point_accept;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: subtract the pivot and pick the pair that rotates
    // ------------------------------------------------------------------
    assign d_x = DW'(s0_point_reg.point_x) - DW'(pivot_x_reg);
    assign d_y = DW'(s0_point_reg.point_y) - DW'(pivot_y_reg);
    assign d_z = DW'(s0_point_reg.point_z) - DW'(pivot_z_reg);

    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                d_u = d_y;
                d_v = d_z;
            end
            AXIS_Y:
            begin
                d_u = d_z;
                d_v = d_x;
            end
            default:
            begin
                d_u = d_x;
                d_v = d_y;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: four products, c*u, s*v, c*v, s*u
    // ------------------------------------------------------------------
    assign prod_cu = cos_value * s1_u_reg;
    assign prod_sv = sin_value * s1_v_reg;
    assign prod_cv = cos_value * s1_v_reg;
    assign prod_su = sin_value * s1_u_reg;

    // ------------------------------------------------------------------
    // Stage 3: round half up, scatter back, add pivot, saturate
    // u' = c*u - s*v, v' = c*v + s*u
    // ------------------------------------------------------------------
    assign acc_u = (PW + 1)'(s2_cu_reg) - (PW + 1)'(s2_sv_reg) + RND_HALF;
    assign acc_v = (PW + 1)'(s2_cv_reg) + (PW + 1)'(s2_su_reg) + RND_HALF;
    assign rot_u = $signed(acc_u[TRIG_FRAC_BITS +: RW]);
    assign rot_v = $signed(acc_v[TRIG_FRAC_BITS +: RW]);

    always_comb
    begin
        sel_x = RW'(s2_dx_reg);
        sel_y = RW'(s2_dy_reg);
        sel_z = RW'(s2_dz_reg);
        // Unused axis code passes all three coordinates through
        case (axis_reg)
            AXIS_X:
            begin
                sel_y = rot_u;
                sel_z = rot_v;
            end
            AXIS_Y:
            begin
                sel_z = rot_u;
                sel_x = rot_v;
            end
            AXIS_Z:
            begin
                sel_x = rot_u;
                sel_y = rot_v;
            end
            default:
            begin
                sel_x = RW'(s2_dx_reg);
            end
        endcase
    end

    assign sat_x = saturate(sel_x + RW'(pivot_x_reg));
    assign sat_y = saturate(sel_y + RW'(pivot_y_reg));
    assign sat_z = saturate(sel_z + RW'(pivot_z_reg));

    always_comb
    begin
        result_next.rotated_x = sat_x[COORD_WIDTH-1:0];
        result_next.rotated_y = sat_y[COORD_WIDTH-1:0];
        result_next.rotated_z = sat_z[COORD_WIDTH-1:0];
        result_next.last_out  = s2_last_reg;
        result_next.overflow  = sat_x[COORD_WIDTH] | sat_y[COORD_WIDTH] | sat_z[COORD_WIDTH];
    end

    // Payload registers: load when the stage advances, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s0_ready && point_accept)
        begin
            s0_point_reg <= point;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_dx_reg   <= d_x;
            s1_dy_reg   <= d_y;
            s1_dz_reg   <= d_z;
            s1_u_reg    <= d_u;
            s1_v_reg    <= d_v;
            s1_last_reg <= s0_point_reg.last_in;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_cu_reg   <= prod_cu;
            s2_sv_reg   <= prod_sv;
            s2_cv_reg   <= prod_cv;
            s2_su_reg   <= prod_su;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_dz_reg   <= s1_dz_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/apr_checker.sv @@
// Port-level checks for axis_point_rotation, attached by the bind below.
// Depends on apr_pkg.
module apr_checker import apr_pkg::*; (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        point_valid,
    input logic                        point_stall,
    input point_in_t                   point,
    input logic                        result_valid,
    input logic                        result_stall,
    input point_out_t                  result,
    input logic                        cfg_write,
    input logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input logic [CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // Stalled input transaction stays on the bus unchanged
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point))
        else $error("point changed or dropped while stalled");

    // Stalled transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // An angle off the whole-degree grid needs the CORDIC run: inputs stall
    a_trig_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_ROTATION_ANGLE) && (cfg_data[7:0] != 8'd0)
        |=> point_stall)
        else $error("points accepted while cosine and sine are refreshed");

    // Overflow only with a coordinate pinned at a limit
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |->
            (result.rotated_x == C_MAX) || (result.rotated_x == C_MIN) ||
            (result.rotated_y == C_MAX) || (result.rotated_y == C_MIN) ||
            (result.rotated_z == C_MAX) || (result.rotated_z == C_MIN))
        else $error("overflow flagged without a saturated coordinate");

endmodule

bind axis_point_rotation apr_checker u_apr_checker (.*);
